// ----- design/ooc_pkg.sv -----
// ----------------------------------------------------------------------------
// ooc_pkg: shared types and constants of the onset order correlator
// Item layouts, channel count, field widths and register indexes.
// ----------------------------------------------------------------------------
package ooc_pkg;

    localparam int CH      = 6;
    localparam int PAIR_W  = CH * CH;
    localparam int TIME_W  = 31;
    localparam int STR_W   = 9;
    localparam int WIN_W   = 31;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 36;

    // A channel is active at a strength of 128 or more.
    localparam logic [STR_W-1:0] ACTIVE_LEVEL = STR_W'(128);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MATRIX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS   = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [CH-1:0]     available_mask;
        logic [STR_W-1:0]  strength_0;
        logic [STR_W-1:0]  strength_1;
        logic [STR_W-1:0]  strength_2;
        logic [STR_W-1:0]  strength_3;
        logic [STR_W-1:0]  strength_4;
        logic [STR_W-1:0]  strength_5;
    } t_in_item;

    typedef struct packed {
        logic [PAIR_W-1:0] transition_mask;
        logic [CH-1:0]     active_mask;
    } t_out_item;

    // Channel state after the latest item, plus that item's time stamp.
    typedef struct packed {
        logic [CH-1:0]             active;
        logic [CH-1:0][TIME_W-1:0] onset;
        logic [TIME_W-1:0]         now_ms;
    } t_snap;

    // Pair bits where source and target are the same channel.
    function automatic logic [PAIR_W-1:0] diag_mask();
        logic [PAIR_W-1:0] m;
        m = '0;
        for (int c = 0; c < CH; c++) begin
            m[c*CH + c] = 1'b1;
        end
        return m;
    endfunction

endpackage

// ----- design/ooc_track.sv -----
// ----------------------------------------------------------------------------
// ooc_track: per-channel activity and onset tracking
// Updates the active flags and onset times when an item is taken.
// ----------------------------------------------------------------------------
module ooc_track (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ooc_pkg::t_in_item i_item,
    output ooc_pkg::t_snap    o_snap
);

    logic [ooc_pkg::STR_W-1:0]  w_str [ooc_pkg::CH];
    logic [ooc_pkg::CH-1:0]     n_active;
    ooc_pkg::t_snap             r_snap;

    assign w_str[0] = i_item.strength_0;
    assign w_str[1] = i_item.strength_1;
    assign w_str[2] = i_item.strength_2;
    assign w_str[3] = i_item.strength_3;
    assign w_str[4] = i_item.strength_4;
    assign w_str[5] = i_item.strength_5;

    always_comb begin
        for (int c = 0; c < ooc_pkg::CH; c++) begin
            n_active[c] = i_item.available_mask[c] && (w_str[c] >= ooc_pkg::ACTIVE_LEVEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap.active <= '0;
            r_snap.onset  <= '1;
            r_snap.now_ms <= '0;
        end else if (i_load) begin
            r_snap.active <= n_active;
            r_snap.now_ms <= i_item.now_ms;
            for (int c = 0; c < ooc_pkg::CH; c++) begin
                if (!n_active[c]) begin
                    r_snap.onset[c] <= '1;
                end else if (!r_snap.active[c]) begin
                    r_snap.onset[c] <= i_item.now_ms;
                end
            end
        end
    end

    assign o_snap = r_snap;

endmodule

// ----- design/ooc_lane.sv -----
// ----------------------------------------------------------------------------
// ooc_lane: one source channel against every target channel
// Produces one row of the transition mask.
// ----------------------------------------------------------------------------
module ooc_lane (
    input  logic                       i_src_active,
    input  logic [ooc_pkg::TIME_W-1:0] i_src_onset,
    input  ooc_pkg::t_snap             i_snap,
    input  logic [ooc_pkg::CH-1:0]     i_edge_row,
    input  logic [ooc_pkg::WIN_W-1:0]  i_window_ms,
    output logic [ooc_pkg::CH-1:0]     o_row
);

    logic [ooc_pkg::TIME_W:0] w_age;
    logic                     w_src_ok;

    // Wrapping age of the source onset; a source onset in the future wraps
    // into the upper half and so exceeds every window.
    assign w_age    = {1'b0, i_snap.now_ms} - {1'b0, i_src_onset};
    assign w_src_ok = i_src_active && (w_age <= {1'b0, i_window_ms});

    always_comb begin
        for (int j = 0; j < ooc_pkg::CH; j++) begin
            o_row[j] = w_src_ok && i_edge_row[j] && i_snap.active[j]
                       && (i_src_onset < i_snap.onset[j])
                       && (i_snap.onset[j] <= i_snap.now_ms);
        end
    end

endmodule

// ----- design/onset_order_correlator_unit.sv -----
// ----------------------------------------------------------------------------
// onset_order_correlator_unit: ordered channel onset correlator
// Tracks channel onsets and reports ordered, windowed onset pairs.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while the output side is not stalled
// and returns exactly one result item for each. An accepted item first
// updates the six channel flags and onset times, and these state registers
// also serve as the first pipeline stage; then six lanes, one per source
// channel, compare that source against all targets in parallel and the
// merged rows are captured in the output register. While the output register
// is full and not taken, the state stage holds its item and the input is
// stalled, so nothing is lost. Configuration writes are accepted in any cycle
// and should only be made while the unit is idle.
module onset_order_correlator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ooc_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ooc_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ooc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ooc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration registers.
    logic [ooc_pkg::PAIR_W-1:0] r_edge_matrix;
    logic [ooc_pkg::WIN_W-1:0]  r_window_ms;

    // Pipeline control.
    logic               r_snap_valid;
    logic               r_out_valid;
    logic               w_in_take;
    logic               w_snap_move;
    ooc_pkg::t_snap     w_snap;
    ooc_pkg::t_out_item r_out_item;
    logic [ooc_pkg::PAIR_W-1:0] w_pairs;
    logic [ooc_pkg::PAIR_W-1:0] w_allowed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_matrix <= '0;
            r_window_ms   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ooc_pkg::REG_EDGE_MATRIX: begin
                    r_edge_matrix <= i_cfg_data[ooc_pkg::PAIR_W-1:0];
                end
                ooc_pkg::REG_WINDOW_MS: begin
                    r_window_ms <= i_cfg_data[ooc_pkg::WIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The state stage moves forward when the output register is free or being
    // emptied in this cycle; a new item may enter whenever the stage is empty
    // or moving on.
    assign w_snap_move = r_snap_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_snap_valid || w_snap_move;
    assign w_in_take   = i_in_valid && o_in_ready;

    ooc_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_in_take),
        .i_item  (i_in_item),
        .o_snap  (w_snap)
    );

    // One lane per source channel; each lane fills one row of the mask.
    for (genvar g = 0; g < ooc_pkg::CH; g++) begin : g_lane
        ooc_lane u_lane (
            .i_src_active (w_snap.active[g]),
            .i_src_onset  (w_snap.onset[g]),
            .i_snap       (w_snap),
            .i_edge_row   (r_edge_matrix[g*ooc_pkg::CH +: ooc_pkg::CH]),
            .i_window_ms  (r_window_ms),
            .o_row        (w_pairs[g*ooc_pkg::CH +: ooc_pkg::CH])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_snap_valid <= 1'b1;
            end else if (w_snap_move) begin
                r_snap_valid <= 1'b0;
            end
            if (w_snap_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Merging stage: the lane rows form the transition mask.
    always_ff @(posedge i_clk) begin
        if (w_snap_move) begin
            r_out_item.transition_mask <= w_pairs;
            r_out_item.active_mask     <= w_snap.active;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Pairs whose source and target are both reported active.
    always_comb begin
        for (int i = 0; i < ooc_pkg::CH; i++) begin
            for (int j = 0; j < ooc_pkg::CH; j++) begin
                w_allowed[i*ooc_pkg::CH + j] = r_out_item.active_mask[i]
                                               && r_out_item.active_mask[j];
            end
        end
    end

    // A reported pair always has both of its channels active.
    a_pair_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_item.transition_mask & ~w_allowed) == '0))
        else $error("transition reported for an inactive channel");

    // A channel never forms a pair with itself, as its onset is not earlier.
    a_no_self_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_item.transition_mask & ooc_pkg::diag_mask()) == '0))
        else $error("self pair reported");

    // The reported activity is the state left by the item that moved on.
    a_active_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_snap_move |=> (r_out_item.active_mask == $past(w_snap.active)))
        else $error("active mask differs from channel state");

    // The state stage never moves while the output holds an untaken item.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_snap_move)
        else $error("output item overwritten before it was taken");

endmodule

// ----- tb/tb_onset_order_correlator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_onset_order_correlator_unit: self-checking bench for the onset correlator
// Sends reading items through the valid/ready input and tracks channel
// onsets in a bench-side model. Each result item is compared field by field,
// in order, against the predicted pair mask and activity mask.
// ----------------------------------------------------------------------------
module tb_onset_order_correlator_unit;

    localparam int CH         = ooc_pkg::CH;
    localparam int PAIR_W     = ooc_pkg::PAIR_W;
    localparam int TIME_W     = ooc_pkg::TIME_W;
    localparam int STR_W      = ooc_pkg::STR_W;
    localparam int WIN_W      = ooc_pkg::WIN_W;
    localparam int CFG_IDX_W  = ooc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ooc_pkg::CFG_DATA_W;

    localparam int                CYCLE_LIMIT   = 200000;
    localparam int                REPORT_MAX    = 10;
    localparam int                IDLE_PERCENT  = 27;
    // This pause lets the pipeline settle before a register write or the final verdict.
    localparam int                SETTLE_CYCLES = 4;
    localparam logic [31:0]       NO_ONSET      = 32'hFFFF_FFFF;
    localparam logic [PAIR_W-1:0] ALL_EDGES     = '1;
    localparam logic [PAIR_W-1:0] NO_EDGES      = '0;
    localparam logic [WIN_W-1:0]  WIDEST_WINDOW = '1;
    localparam logic [WIN_W-1:0]  ZERO_WINDOW   = '0;

    // Every input of the block starts at a known value.
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    ooc_pkg::t_in_item     in_item   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = ooc_pkg::REG_EDGE_MATRIX;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_cfg_ready;
    ooc_pkg::t_out_item    o_out_item;

    // Bench copy of the configuration and of the per-channel state.
    logic [PAIR_W-1:0]     edge_cfg    = '0;
    logic [WIN_W-1:0]      window_cfg  = '0;
    logic [CH-1:0]         chan_active = '0;
    logic [31:0]           chan_onset [CH];
    ooc_pkg::t_out_item    expected_masks [$];

    // Idling control shared by both sides, and the receiver hold-off count.
    logic                  gaps_on    = 1'b1;
    int                    hold_left  = 0;
    int                    cycles     = 0;
    int                    mismatches = 0;

    // Running time stamp and intended channel states of generated readings.
    logic [TIME_W-1:0]     clock_ms    = '0;
    logic [CH-1:0]         want_active = '0;

    always #2 i_clk = ~i_clk;

    onset_order_correlator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side. A pending hold-off keeps ready low while it counts down;
    // otherwise ready drops at random while idling is enabled.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            out_ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("mismatch in %s: expected %h, got %h", what, want, got);
        end
    endtask

    // Every accepted result item is matched against the oldest prediction.
    // Values are sampled right after the edge, so they are the pre-edge ones.
    always @(posedge i_clk) begin
        ooc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_masks.size() == 0) begin
                report_mismatch("unexpected result item", '0, o_out_item);
            end else begin
                want = expected_masks.pop_front();
                if (o_out_item.transition_mask !== want.transition_mask) begin
                    report_mismatch("transition_mask", want.transition_mask,
                                    o_out_item.transition_mask);
                end
                if (o_out_item.active_mask !== want.active_mask) begin
                    report_mismatch("active_mask", want.active_mask,
                                    o_out_item.active_mask);
                end
            end
        end
    end

    // Applies one reading to the bench state and returns the result it
    // must produce. A channel is active when it is available and at a
    // strength of 128 or more. A rising channel stamps its onset and a falling
    // one clears it. A pair fires when the edge is enabled, both ends are
    // active, the source started strictly first, the target onset is not
    // in the future, and the wrapping 32-bit age of the source onset is
    // within the window. A source onset in the future wraps to a huge age.
    function automatic ooc_pkg::t_out_item track_onsets(input ooc_pkg::t_in_item it);
        logic [STR_W-1:0]   lvl [CH];
        logic [31:0]        now32;
        logic [31:0]        span;
        logic               is_on;
        ooc_pkg::t_out_item r;
        int                 b;
        lvl[0] = it.strength_0;
        lvl[1] = it.strength_1;
        lvl[2] = it.strength_2;
        lvl[3] = it.strength_3;
        lvl[4] = it.strength_4;
        lvl[5] = it.strength_5;
        now32  = {1'b0, it.now_ms};
        r      = '0;
        for (int c = 0; c < CH; c++) begin
            is_on = it.available_mask[c] && (lvl[c] >= ooc_pkg::ACTIVE_LEVEL);
            if (is_on && !chan_active[c]) begin
                chan_onset[c] = now32;
            end
            if (!is_on) begin
                chan_onset[c] = NO_ONSET;
            end
            chan_active[c] = is_on;
        end
        r.active_mask = chan_active;
        for (int i = 0; i < CH; i++) begin
            for (int j = 0; j < CH; j++) begin
                b    = i * CH + j;
                span = now32 - chan_onset[i];
                if (edge_cfg[b] && chan_active[i] && chan_active[j]
                        && chan_onset[i] < chan_onset[j]
                        && chan_onset[j] <= now32
                        && span <= {1'b0, window_cfg}) begin
                    r.transition_mask[b] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Offers one reading item, possibly after a few idle cycles, and holds
    // it until accepted. Valid is only lowered in an idle cycle, never in
    // the step that raises it again.
    task automatic send_reading(input ooc_pkg::t_in_item it);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        expected_masks.push_back(track_onsets(it));
    endtask

    // Called right after the last acceptance: lowers valid, waits for
    // every predicted result item, then lets the pipeline settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_masks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers back to back while the block is idle.
    task automatic configure(input logic [PAIR_W-1:0] edges,
                             input logic [WIN_W-1:0] window);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= ooc_pkg::REG_EDGE_MATRIX;
        cfg_data  <= CFG_DATA_W'(edges);
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        edge_cfg = edges;
        cfg_index <= ooc_pkg::REG_WINDOW_MS;
        cfg_data  <= CFG_DATA_W'(window);
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        window_cfg = window;
        cfg_valid <= 1'b0;
    endtask

    // Strength literals are written channel 5 first, channel 0 last.
    function automatic ooc_pkg::t_in_item make_reading(input logic [TIME_W-1:0] now,
                                                       input logic [CH-1:0] avail,
                                                       input logic [CH-1:0][STR_W-1:0] lvls);
        ooc_pkg::t_in_item it;
        it.now_ms         = now;
        it.available_mask = avail;
        it.strength_0     = lvls[0];
        it.strength_1     = lvls[1];
        it.strength_2     = lvls[2];
        it.strength_3     = lvls[3];
        it.strength_4     = lvls[4];
        it.strength_5     = lvls[5];
        return it;
    endfunction

    // Generates plausible monitoring traffic: time mostly moves forward in
    // small steps, channels switch on and off now and then, and a few items
    // carry jumps, time going backwards, dropped availability or noise.
    task automatic run_readings(input int count);
        logic [CH-1:0][STR_W-1:0] lvls;
        logic [CH-1:0]            avail;
        int                       pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // Same millisecond as the previous reading.
            end else if (pick < 85) begin
                clock_ms = clock_ms + TIME_W'($urandom_range(1, 20));
            end else if (pick < 93) begin
                clock_ms = clock_ms + TIME_W'($urandom_range(21, 5000));
            end else if (pick < 97) begin
                clock_ms = clock_ms - TIME_W'($urandom_range(1, 50));
            end else begin
                clock_ms = TIME_W'($urandom);
            end
            for (int c = 0; c < CH; c++) begin
                if ($urandom_range(0, 99) < 15) begin
                    want_active[c] = !want_active[c];
                end
                if ($urandom_range(0, 99) < 5) begin
                    lvls[c] = STR_W'($urandom);
                end else if (want_active[c]) begin
                    lvls[c] = STR_W'($urandom_range(128, 511));
                end else begin
                    lvls[c] = STR_W'($urandom_range(0, 127));
                end
            end
            avail = ($urandom_range(0, 99) < 10) ? CH'($urandom) : '1;
            send_reading(make_reading(clock_ms, avail, lvls));
        end
    endtask

    // Hand-picked readings: thresholds, strengths at full scale, equal
    // onsets, time going backwards and wrapping, availability drops, the
    // extremes of every register, and the exact window boundary.
    task automatic test_directed_cases();
        configure(ALL_EDGES, WIDEST_WINDOW);
        send_reading(make_reading(31'd0, 6'h00, {CH{9'd0}}));
        // Channel 0 exactly at the threshold, channel 1 just below, channel 2 masked.
        send_reading(make_reading(31'd10, 6'b111011,
                                  {9'd0, 9'd0, 9'd0, 9'd256, 9'd127, 9'd128}));
        // Channel 1 at full scale joins with channel 2.
        send_reading(make_reading(31'd20, 6'h3F,
                                  {9'd0, 9'd0, 9'd0, 9'd256, 9'd511, 9'd128}));
        send_reading(make_reading(31'd20, 6'h3F,
                                  {9'd0, 9'd0, 9'd0, 9'd256, 9'd511, 9'd128}));
        // Channels 3 to 5 start together and never pair among themselves.
        send_reading(make_reading(31'd35, 6'h3F, {CH{9'd256}}));
        // Time going backwards keeps the onsets and blocks every pair.
        send_reading(make_reading(31'd5, 6'h3F, {CH{9'd256}}));
        send_reading(make_reading(31'h7FFF_FFFF, 6'h3F, {CH{9'd256}}));
        send_reading(make_reading(31'd0, 6'h3F, {CH{9'd256}}));
        // Channel 0 drops out and comes back later than all others.
        send_reading(make_reading(31'd40, 6'h3E, {CH{9'd256}}));
        send_reading(make_reading(31'd41, 6'h3F, {CH{9'd256}}));
        send_reading(make_reading(31'h5555_5555, 6'h2A,
                                  {9'h155, 9'h0AA, 9'h155, 9'h0AA, 9'h155, 9'h1FF}));
        send_reading(make_reading(31'h2AAA_AAAA, 6'h15,
                                  {9'h055, 9'h0AA, 9'h055, 9'h0AA, 9'h055, 9'h0AA}));
        send_reading(make_reading(31'h2AAA_AAB0, 6'h3F, {CH{9'h1FF}}));

        configure(NO_EDGES, ZERO_WINDOW);
        send_reading(make_reading(31'd100, 6'h00, {CH{9'd0}}));
        send_reading(make_reading(31'd110, 6'h3F, {CH{9'd200}}));

        configure(ALL_EDGES, ZERO_WINDOW);
        send_reading(make_reading(31'd120, 6'h01, {CH{9'd200}}));
        send_reading(make_reading(31'd130, 6'h3F, {CH{9'd200}}));

        // Only the edge from channel 0 to channel 1, window of 15 ms.
        configure(PAIR_W'(1) << 1, 31'd15);
        send_reading(make_reading(31'd200, 6'h00, {CH{9'd0}}));
        send_reading(make_reading(31'd300, 6'h01, {CH{9'd256}}));
        send_reading(make_reading(31'd310, 6'h03, {CH{9'd256}}));
        send_reading(make_reading(31'd315, 6'h03, {CH{9'd256}}));
        send_reading(make_reading(31'd316, 6'h03, {CH{9'd256}}));
    endtask

    // Segments of random traffic under changing register settings; one
    // segment runs without any idling on either side.
    task automatic test_random_sequences();
        logic [PAIR_W-1:0] edges;
        logic [WIN_W-1:0]  window;
        for (int seg = 0; seg < 8; seg++) begin
            edges  = PAIR_W'({$urandom, $urandom});
            window = ($urandom_range(0, 99) < 80) ? WIN_W'($urandom_range(0, 200))
                                                  : WIN_W'($urandom);
            case (seg)
                0: begin
                    edges  = ALL_EDGES;
                    window = WIDEST_WINDOW;
                end
                1: begin
                    edges = ALL_EDGES;
                end
                2: begin
                    edges  = NO_EDGES;
                    window = ZERO_WINDOW;
                end
                default: begin
                end
            endcase
            configure(edges, window);
            if ($urandom_range(0, 3) == 0) begin
                clock_ms = TIME_W'($urandom);
            end
            gaps_on = (seg != 3);
            run_readings(95);
        end
        gaps_on = 1'b1;
    endtask

    // The result side holds off for a long stretch while readings keep
    // coming, so the pipeline fills and the input stalls.
    task automatic test_output_backpressure();
        configure(ALL_EDGES, 31'd100);
        gaps_on   = 1'b0;
        hold_left = 300;
        run_readings(40);
        gaps_on = 1'b1;
    endtask

    initial begin
        foreach (chan_onset[c]) begin
            chan_onset[c] = NO_ONSET;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_random_sequences();
        test_output_backpressure();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_masks.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
